/* hw/rtl/x86dec_pkg.sv */
// Shared types, constants and table functions for the x86 prefix, ModR/M and SIB decoder.
package x86dec_pkg;

   localparam int MaxPrefixes = 4;
   localparam int WindowBytes = 16;
   localparam int ScanBytes   = 15;
   localparam int WindowBits  = WindowBytes * 8;

   localparam logic [7:0] PrefLock  = 8'hF0;
   localparam logic [7:0] PrefRepnz = 8'hF2;
   localparam logic [7:0] PrefRep   = 8'hF3;
   localparam logic [7:0] PrefOpsz  = 8'h66;
   localparam logic [7:0] PrefAdsz  = 8'h67;
   localparam logic [7:0] PrefSegEs = 8'h26;
   localparam logic [7:0] PrefSegCs = 8'h2E;
   localparam logic [7:0] PrefSegSs = 8'h36;
   localparam logic [7:0] PrefSegDs = 8'h3E;
   localparam logic [7:0] PrefSegFs = 8'h64;
   localparam logic [7:0] PrefSegGs = 8'h65;

   localparam logic [3:0] FlagRepnz = 4'b0001;
   localparam logic [3:0] FlagRep   = 4'b0010;
   localparam logic [3:0] FlagOpsz  = 4'b0100;
   localparam logic [3:0] FlagAdsz  = 4'b1000;

   localparam logic [2:0] SegNone = 3'd0;
   localparam logic [2:0] SegEs   = 3'd1;
   localparam logic [2:0] SegCs   = 3'd2;
   localparam logic [2:0] SegSs   = 3'd3;
   localparam logic [2:0] SegDs   = 3'd4;
   localparam logic [2:0] SegFs   = 3'd5;
   localparam logic [2:0] SegGs   = 3'd6;

   localparam logic [3:0] RegNone = 4'd8;

   localparam logic [1:0] ModIndirect = 2'd0;
   localparam logic [1:0] ModDisp8    = 2'd1;
   localparam logic [1:0] ModDisp32   = 2'd2;
   localparam logic [1:0] ModRegister = 2'd3;

   localparam logic [2:0] RmSib     = 3'd4;
   localparam logic [2:0] RmDisp32  = 3'd5;
   localparam logic [2:0] SibNoIdx  = 3'd4;
   localparam logic [2:0] SibNoBase = 3'd5;

   localparam logic [2:0] DispNone  = 3'd0;
   localparam logic [2:0] DispByte  = 3'd1;
   localparam logic [2:0] DispDword = 3'd4;

   typedef struct packed {
      logic       is_prefix;
      logic [3:0] flags;
      logic [2:0] seg;
   } prefix_class_type;

   typedef struct packed {
      logic [3:0] count;
      logic [3:0] flags;
      logic [2:0] seg;
   } prefix_info_type;

   typedef struct packed {
      logic [3:0] base;
      logic [2:0] disp_bytes;
      logic       has_sib;
   } modrm_entry_type;

   function automatic prefix_class_type classify_prefix(input logic [7:0] b);
      prefix_class_type c;
      c.is_prefix = 1'b1;
      c.flags     = 4'b0000;
      c.seg       = SegNone;
      case (b)
         PrefLock:  c.flags = 4'b0000;
         PrefRepnz: c.flags = FlagRepnz;
         PrefRep:   c.flags = FlagRep;
         PrefOpsz:  c.flags = FlagOpsz;
         PrefAdsz:  c.flags = FlagAdsz;
         PrefSegEs: c.seg   = SegEs;
         PrefSegCs: c.seg   = SegCs;
         PrefSegSs: c.seg   = SegSs;
         PrefSegDs: c.seg   = SegDs;
         PrefSegFs: c.seg   = SegFs;
         PrefSegGs: c.seg   = SegGs;
         default:   c.is_prefix = 1'b0;
      endcase
      return c;
   endfunction

   function automatic modrm_entry_type modrm_entry(input logic [1:0] md, input logic [2:0] rm);
      modrm_entry_type e;
      e.base       = {1'b0, rm};
      e.disp_bytes = DispNone;
      e.has_sib    = 1'b0;
      case (md)
         ModIndirect: begin
            if (rm == RmSib) begin
               e.base    = RegNone;
               e.has_sib = 1'b1;
            end else if (rm == RmDisp32) begin
               e.base       = RegNone;
               e.disp_bytes = DispDword;
            end
         end
         ModDisp8: begin
            e.disp_bytes = DispByte;
            if (rm == RmSib) begin
               e.base    = RegNone;
               e.has_sib = 1'b1;
            end
         end
         ModDisp32: begin
            e.disp_bytes = DispDword;
            if (rm == RmSib) begin
               e.base    = RegNone;
               e.has_sib = 1'b1;
            end
         end
         default: e.base = RegNone;
      endcase
      return e;
   endfunction

   function automatic logic [3:0] scale_of(input logic [1:0] ss);
      logic [3:0] s;
      case (ss)
         2'd0:    s = 4'd1;
         2'd1:    s = 4'd2;
         2'd2:    s = 4'd4;
         default: s = 4'd8;
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/x86dec_prefix_scan.sv */
// Leading prefix scan: prefix count, prefix flags and last segment override.
module x86dec_prefix_scan (
   input  logic [x86dec_pkg::WindowBits-1:0] window,
   output x86dec_pkg::prefix_info_type       info
);

   always_comb begin
      x86dec_pkg::prefix_class_type cls;
      logic scanning;
      info.count = 4'(x86dec_pkg::ScanBytes);
      info.flags = 4'b0000;
      info.seg   = x86dec_pkg::SegNone;
      scanning   = 1'b1;
      for (int i = 0; i < x86dec_pkg::ScanBytes; i++) begin
         cls = x86dec_pkg::classify_prefix(window[i*8 +: 8]);
         if (scanning) begin
            if (cls.is_prefix) begin
               info.flags = info.flags | cls.flags;
               if (cls.seg != x86dec_pkg::SegNone) begin
                  info.seg = cls.seg;
               end
            end else begin
               scanning   = 1'b0;
               info.count = 4'(i);
            end
         end
      end
   end

endmodule

/* hw/rtl/x86_prefix_modrm_sib_decoder_top.sv */
// Top level of the x86 prefix, ModR/M and SIB decoder pipeline.
// Accepts one instruction word per clock while req_ready is high and returns one decoded word per
// accepted word, in order. Four register stages hold the pipeline: prefix scan, alignment of
// the window to the opcode, ModR/M and SIB decode, then displacement, immediate and length
// extraction into the output register. A stall at rsp_ready backs up stage by stage; empty
// stages keep filling, so throughput stays at one word per cycle whenever rsp_ready is high.
module x86_prefix_modrm_sib_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_window_low,
   input  logic [63:0]        req_window_high,
   input  logic [1:0]         req_opcode_length,
   input  logic               req_has_modrm,
   input  logic [2:0]         req_immediate_length,
   input  logic [4:0]         req_index_shift,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_prefix_flags,
   output logic [2:0]         rsp_segment_override,
   output logic [7:0]         rsp_modrm_value,
   output logic [3:0]         rsp_base_register,
   output logic [3:0]         rsp_index_register,
   output logic [3:0]         rsp_scale_factor,
   output logic signed [31:0] rsp_displacement,
   output logic [31:0]        rsp_immediate_value,
   output logic [2:0]         rsp_register_index,
   output logic [3:0]         rsp_total_length,
   output logic               rsp_decode_error
);

   localparam int WB = x86dec_pkg::WindowBits;

   logic adv1, adv2, adv3, adv4;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   // stage 1 inputs
   logic [WB-1:0]                 win_in;
   x86dec_pkg::prefix_info_type   pinfo_in;

   // stage 1 registers
   logic [WB-1:0]                 s1_win_ff;
   x86dec_pkg::prefix_info_type   s1_pinfo_ff;
   logic [1:0]                    s1_oplen_ff;
   logic                          s1_modrm_ff;
   logic [2:0]                    s1_immlen_ff;
   logic [4:0]                    s1_shift_ff;

   // stage 2
   logic [WB-1:0]                 s2_win_in;
   logic [2:0]                    s2_regidx_in;
   logic [WB-1:0]                 s2_win_ff;
   x86dec_pkg::prefix_info_type   s2_pinfo_ff;
   logic [1:0]                    s2_oplen_ff;
   logic                          s2_modrm_ff;
   logic [2:0]                    s2_immlen_ff;
   logic [2:0]                    s2_regidx_ff;

   // stage 3
   logic [7:0]                    s3_modrm_in;
   logic [3:0]                    s3_base_in, s3_index_in, s3_scale_in;
   logic [2:0]                    s3_dsize_in;
   logic [3:0]                    s3_doff_in, s3_ioff_in;
   logic [WB-1:0]                 s3_win_ff;
   x86dec_pkg::prefix_info_type   s3_pinfo_ff;
   logic [2:0]                    s3_immlen_ff;
   logic [2:0]                    s3_regidx_ff;
   logic [7:0]                    s3_modrm_ff;
   logic [3:0]                    s3_base_ff, s3_index_ff, s3_scale_ff;
   logic [2:0]                    s3_dsize_ff;
   logic [3:0]                    s3_doff_ff, s3_ioff_ff;

   // stage 4 (output register)
   logic [31:0]                   disp_in, imm_in;
   logic [3:0]                    total_in;
   logic                          err_in;
   logic [3:0]                    flags_ff;
   logic [2:0]                    seg_ff;
   logic [7:0]                    modrm_ff;
   logic [3:0]                    base_ff, index_ff, scale_ff;
   logic [31:0]                   disp_ff, imm_ff;
   logic [2:0]                    regidx_ff;
   logic [3:0]                    total_ff;
   logic                          err_ff;

   assign adv4      = !rsp_valid_ff || rsp_ready;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv4) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // stage 1: prefix scan
   assign win_in = {req_window_high, req_window_low};

   x86dec_prefix_scan u_scan (
      .window (win_in),
      .info   (pinfo_in)
   );

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_win_ff    <= win_in;
         s1_pinfo_ff  <= pinfo_in;
         s1_oplen_ff  <= (req_opcode_length == 2'd0) ? 2'd1 : req_opcode_length;
         s1_modrm_ff  <= req_has_modrm;
         s1_immlen_ff <= req_immediate_length;
         s1_shift_ff  <= req_index_shift;
      end
   end

   // stage 2: align window to the opcode, pick the register index
   always_comb begin
      logic [31:0] opword;
      s2_win_in    = s1_win_ff >> {s1_pinfo_ff.count, 3'b000};
      opword       = s2_win_in[31:0];
      s2_regidx_in = 3'(opword >> s1_shift_ff);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_win_ff    <= s2_win_in;
         s2_pinfo_ff  <= s1_pinfo_ff;
         s2_oplen_ff  <= s1_oplen_ff;
         s2_modrm_ff  <= s1_modrm_ff;
         s2_immlen_ff <= s1_immlen_ff;
         s2_regidx_ff <= s2_regidx_in;
      end
   end

   // stage 3: ModR/M and SIB decode
   always_comb begin
      x86dec_pkg::modrm_entry_type ent;
      logic [3:0] mpos, spos;
      logic [7:0] mbyte, sib;
      mpos        = {2'b00, s2_oplen_ff};
      spos        = mpos + 4'd1;
      mbyte       = s2_win_ff[{mpos, 3'b000} +: 8];
      sib         = s2_win_ff[{spos, 3'b000} +: 8];
      ent         = x86dec_pkg::modrm_entry(mbyte[7:6], mbyte[2:0]);
      s3_modrm_in = 8'd0;
      s3_base_in  = x86dec_pkg::RegNone;
      s3_index_in = x86dec_pkg::RegNone;
      s3_scale_in = 4'd0;
      s3_dsize_in = x86dec_pkg::DispNone;
      s3_doff_in  = mpos;
      s3_ioff_in  = mpos;
      if (s2_modrm_ff) begin
         s3_modrm_in = mbyte;
         s3_base_in  = ent.base;
         s3_dsize_in = ent.disp_bytes;
         s3_doff_in  = spos;
         if (ent.has_sib) begin
            s3_scale_in = x86dec_pkg::scale_of(sib[7:6]);
            s3_index_in = (sib[5:3] == x86dec_pkg::SibNoIdx) ? x86dec_pkg::RegNone
                                                             : {1'b0, sib[5:3]};
            s3_base_in  = {1'b0, sib[2:0]};
            if (sib[2:0] == x86dec_pkg::SibNoBase && mbyte[7:6] == x86dec_pkg::ModIndirect) begin
               s3_base_in  = x86dec_pkg::RegNone;
               s3_dsize_in = x86dec_pkg::DispDword;
            end
            s3_doff_in = spos + 4'd1;
         end
         s3_ioff_in = s3_doff_in + {1'b0, s3_dsize_in};
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_win_ff    <= s2_win_ff;
         s3_pinfo_ff  <= s2_pinfo_ff;
         s3_immlen_ff <= s2_immlen_ff;
         s3_regidx_ff <= s2_regidx_ff;
         s3_modrm_ff  <= s3_modrm_in;
         s3_base_ff   <= s3_base_in;
         s3_index_ff  <= s3_index_in;
         s3_scale_ff  <= s3_scale_in;
         s3_dsize_ff  <= s3_dsize_in;
         s3_doff_ff   <= s3_doff_in;
         s3_ioff_ff   <= s3_ioff_in;
      end
   end

   // stage 4: displacement, immediate, length and error
   always_comb begin
      logic [31:0] draw, iraw;
      logic [2:0]  ilen;
      logic        bad_imm;
      logic [4:0]  sum;
      draw    = s3_win_ff[{s3_doff_ff, 3'b000} +: 32];
      iraw    = s3_win_ff[{s3_ioff_ff, 3'b000} +: 32];
      bad_imm = 1'b0;
      case (s3_immlen_ff)
         3'd0: begin
            ilen   = 3'd0;
            imm_in = 32'd0;
         end
         3'd1: begin
            ilen   = 3'd1;
            imm_in = {24'd0, iraw[7:0]};
         end
         3'd2: begin
            ilen   = 3'd2;
            imm_in = {16'd0, iraw[15:0]};
         end
         3'd4: begin
            ilen   = 3'd4;
            imm_in = iraw;
         end
         default: begin
            ilen    = 3'd0;
            imm_in  = 32'd0;
            bad_imm = 1'b1;
         end
      endcase
      case (s3_dsize_ff)
         x86dec_pkg::DispByte:  disp_in = {{24{draw[7]}}, draw[7:0]};
         x86dec_pkg::DispDword: disp_in = draw;
         default:               disp_in = 32'd0;
      endcase
      sum      = {1'b0, s3_pinfo_ff.count} + {1'b0, s3_ioff_ff} + {2'b00, ilen};
      total_in = (sum > 5'd15) ? 4'd15 : sum[3:0];
      err_in   = (s3_pinfo_ff.count > 4'(x86dec_pkg::MaxPrefixes)) || bad_imm || (sum > 5'd15);
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         flags_ff  <= s3_pinfo_ff.flags;
         seg_ff    <= s3_pinfo_ff.seg;
         modrm_ff  <= s3_modrm_ff;
         base_ff   <= s3_base_ff;
         index_ff  <= s3_index_ff;
         scale_ff  <= s3_scale_ff;
         disp_ff   <= disp_in;
         imm_ff    <= imm_in;
         regidx_ff <= s3_regidx_ff;
         total_ff  <= total_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_prefix_flags     = flags_ff;
   assign rsp_segment_override = seg_ff;
   assign rsp_modrm_value      = modrm_ff;
   assign rsp_base_register    = base_ff;
   assign rsp_index_register   = index_ff;
   assign rsp_scale_factor     = scale_ff;
   assign rsp_displacement     = disp_ff;
   assign rsp_immediate_value  = imm_ff;
   assign rsp_register_index   = regidx_ff;
   assign rsp_total_length     = total_ff;
   assign rsp_decode_error     = err_ff;

endmodule

/* hw/rtl/x86dec_checker.sv */
// Port-level checker for the decoder top level, with its bind.
module x86dec_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_modrm_value,
   input logic [3:0]         rsp_base_register,
   input logic [3:0]         rsp_index_register,
   input logic [3:0]         rsp_scale_factor,
   input logic signed [31:0] rsp_displacement,
   input logic [3:0]         rsp_total_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_displacement)
                                 && $stable(rsp_total_length))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_no_sib_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scale_factor == 4'd0 |-> rsp_index_register == x86dec_pkg::RegNone)
      else $error("index register without SIB");

   a_register_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modrm_value[7:6] == x86dec_pkg::ModRegister
      |-> rsp_base_register == x86dec_pkg::RegNone && rsp_scale_factor == 4'd0
          && rsp_displacement == 32'sd0)
      else $error("register form produced an address operand");

endmodule

bind x86_prefix_modrm_sib_decoder_top x86dec_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_modrm_value    (rsp_modrm_value),
   .rsp_base_register  (rsp_base_register),
   .rsp_index_register (rsp_index_register),
   .rsp_scale_factor   (rsp_scale_factor),
   .rsp_displacement   (rsp_displacement),
   .rsp_total_length   (rsp_total_length)
);

/* bench/x86_prefix_modrm_sib_decoder_top_tb.sv */
// Self-checking testbench for the x86 prefix, ModR/M and SIB decoder top level.
module x86_prefix_modrm_sib_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] window_low;
      logic [63:0] window_high;
      logic [1:0]  opcode_length;
      logic        has_modrm;
      logic [2:0]  immediate_length;
      logic [4:0]  index_shift;
      logic        drain;
   } instr_word_type;

   typedef struct packed {
      logic [3:0]         flags;
      logic [2:0]         seg;
      logic [7:0]         modrm;
      logic [3:0]         base;
      logic [3:0]         index;
      logic [3:0]         scale;
      logic signed [31:0] disp;
      logic [31:0]        imm;
      logic [2:0]         reg_index;
      logic [3:0]         total;
      logic               err;
   } decode_result_type;

   localparam logic [7:0] PrefixBytes [11] = '{
      x86dec_pkg::PrefLock, x86dec_pkg::PrefRepnz, x86dec_pkg::PrefRep,
      x86dec_pkg::PrefOpsz, x86dec_pkg::PrefAdsz, x86dec_pkg::PrefSegEs,
      x86dec_pkg::PrefSegCs, x86dec_pkg::PrefSegSs, x86dec_pkg::PrefSegDs,
      x86dec_pkg::PrefSegFs, x86dec_pkg::PrefSegGs
   };
   localparam logic [2:0] ImmLengths [4] = '{3'd0, 3'd1, 3'd2, 3'd4};
   localparam int RandomWords = 1600;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [63:0]        req_window_low = '0;
   logic [63:0]        req_window_high = '0;
   logic [1:0]         req_opcode_length = '0;
   logic               req_has_modrm = 1'b0;
   logic [2:0]         req_immediate_length = '0;
   logic [4:0]         req_index_shift = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_prefix_flags;
   logic [2:0]         rsp_segment_override;
   logic [7:0]         rsp_modrm_value;
   logic [3:0]         rsp_base_register;
   logic [3:0]         rsp_index_register;
   logic [3:0]         rsp_scale_factor;
   logic signed [31:0] rsp_displacement;
   logic [31:0]        rsp_immediate_value;
   logic [2:0]         rsp_register_index;
   logic [3:0]         rsp_total_length;
   logic               rsp_decode_error;

   instr_word_type    pending_words [$];
   decode_result_type expected_decodes [$];
   instr_word_type    driven_word;
   logic              word_taken = 1'b0;
   int                send_gap = 0;
   int                send_calm = 0;
   int                stall_left = 0;
   int                stall_calm = 0;
   int                mismatch_count = 0;
   int                words_checked = 0;
   int                error_words = 0;
   int                sib_words = 0;
   int                directed_words = 0;

   x86_prefix_modrm_sib_decoder_top uut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic is_prefix_byte(input logic [7:0] b);
      foreach (PrefixBytes[i]) begin
         if (b == PrefixBytes[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] window_byte(input logic [127:0] w, input int unsigned pos);
      if (pos < 16) return w[pos*8 +: 8];
      return 8'h00;
   endfunction

   function automatic logic [31:0] window_le(input logic [127:0] w, input int unsigned pos,
                                             input int unsigned n);
      logic [31:0] v;
      v = '0;
      for (int unsigned i = 0; i < n; i++) v[8*i +: 8] = window_byte(w, pos + i);
      return v;
   endfunction

   function automatic decode_result_type decode_expect(input instr_word_type it);
      decode_result_type r;
      logic [127:0]      w;
      logic [7:0]        b;
      logic [7:0]        s;
      logic [1:0]        md;
      logic [2:0]        rm;
      logic              scanning;
      logic              sib_present;
      int unsigned       count;
      int unsigned       pos;
      int unsigned       dbytes;
      r = '0;
      r.seg = x86dec_pkg::SegNone;
      r.base = x86dec_pkg::RegNone;
      r.index = x86dec_pkg::RegNone;
      w = {it.window_high, it.window_low};
      count = 0;
      scanning = 1'b1;
      while (scanning && count < x86dec_pkg::ScanBytes) begin
         b = window_byte(w, count);
         case (b)
            x86dec_pkg::PrefLock:  ;
            x86dec_pkg::PrefRepnz: r.flags |= x86dec_pkg::FlagRepnz;
            x86dec_pkg::PrefRep:   r.flags |= x86dec_pkg::FlagRep;
            x86dec_pkg::PrefOpsz:  r.flags |= x86dec_pkg::FlagOpsz;
            x86dec_pkg::PrefAdsz:  r.flags |= x86dec_pkg::FlagAdsz;
            x86dec_pkg::PrefSegEs: r.seg = x86dec_pkg::SegEs;
            x86dec_pkg::PrefSegCs: r.seg = x86dec_pkg::SegCs;
            x86dec_pkg::PrefSegSs: r.seg = x86dec_pkg::SegSs;
            x86dec_pkg::PrefSegDs: r.seg = x86dec_pkg::SegDs;
            x86dec_pkg::PrefSegFs: r.seg = x86dec_pkg::SegFs;
            x86dec_pkg::PrefSegGs: r.seg = x86dec_pkg::SegGs;
            default:               scanning = 1'b0;
         endcase
         if (scanning) count++;
      end
      r.err = (count > x86dec_pkg::MaxPrefixes);
      r.reg_index = 3'(window_le(w, count, 4) >> it.index_shift);
      pos = count + ((it.opcode_length == 2'd0) ? 1 : 32'(it.opcode_length));

      if (it.has_modrm) begin
         r.modrm = window_byte(w, pos);
         pos++;
         md = r.modrm[7:6];
         rm = r.modrm[2:0];
         dbytes = 0;
         sib_present = 1'b0;
         if (md != x86dec_pkg::ModRegister) begin
            r.base = {1'b0, rm};
            if (md == x86dec_pkg::ModDisp8) dbytes = 1;
            if (md == x86dec_pkg::ModDisp32) dbytes = 4;
            if (rm == x86dec_pkg::RmSib) begin
               sib_present = 1'b1;
            end else if (md == x86dec_pkg::ModIndirect && rm == x86dec_pkg::RmDisp32) begin
               r.base = x86dec_pkg::RegNone;
               dbytes = 4;
            end
         end
         if (sib_present) begin
            s = window_byte(w, pos);
            pos++;
            r.scale = 4'd1 << s[7:6];
            r.index = (s[5:3] == x86dec_pkg::SibNoIdx) ? x86dec_pkg::RegNone : {1'b0, s[5:3]};
            r.base = {1'b0, s[2:0]};
            if (s[2:0] == x86dec_pkg::SibNoBase && md == x86dec_pkg::ModIndirect) begin
               r.base = x86dec_pkg::RegNone;
               dbytes = 4;
            end
         end
         if (dbytes == 1) begin
            b = window_byte(w, pos);
            r.disp = {{24{b[7]}}, b};
         end else if (dbytes == 4) begin
            r.disp = window_le(w, pos, 4);
         end
         pos += dbytes;
      end

      case (it.immediate_length)
         3'd0: ;
         3'd1, 3'd2, 3'd4: begin
            r.imm = window_le(w, pos, 32'(it.immediate_length));
            pos += 32'(it.immediate_length);
         end
         default: r.err = 1'b1;
      endcase

      if (pos > x86dec_pkg::ScanBytes) begin
         r.total = 4'(x86dec_pkg::ScanBytes);
         r.err = 1'b1;
      end else begin
         r.total = 4'(pos);
      end
      return r;
   endfunction

   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic instr_word_type random_word();
      instr_word_type it;
      logic [127:0]   w;
      logic [7:0]     op;
      int unsigned    npref;
      int unsigned    r;
      w = {$urandom, $urandom, $urandom, $urandom};
      it = '0;
      it.index_shift = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 15) begin
         it.opcode_length = 2'($urandom_range(0, 3));
         it.has_modrm = 1'($urandom_range(0, 1));
         it.immediate_length = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 16; i++) begin
               if ($urandom_range(0, 3) != 0) w[i*8 +: 8] = PrefixBytes[$urandom_range(0, 10)];
            end
         end
      end else begin
         r = $urandom_range(0, 99);
         npref = (r < 30) ? 0 :
                 (r < 85) ? $urandom_range(1, x86dec_pkg::MaxPrefixes) :
                            $urandom_range(x86dec_pkg::MaxPrefixes + 1, 8);
         for (int unsigned i = 0; i < npref; i++) begin
            w[i*8 +: 8] = PrefixBytes[$urandom_range(0, 10)];
         end
         do op = 8'($urandom); while (is_prefix_byte(op));
         w[npref*8 +: 8] = op;
         it.opcode_length = 2'($urandom_range(1, 3));
         it.has_modrm = ($urandom_range(0, 9) != 0);
         it.immediate_length = ImmLengths[$urandom_range(0, 3)];
         if (it.has_modrm && $urandom_range(0, 3) == 0) begin
            w[(npref + it.opcode_length)*8 +: 3] = x86dec_pkg::RmSib;
         end
      end
      it.window_low = w[63:0];
      it.window_high = w[127:64];
      return it;
   endfunction

   task automatic add_word(input logic [127:0] w, input logic [1:0] ol, input logic hm,
                           input logic [2:0] il, input logic [4:0] sh, input logic drain);
      instr_word_type it;
      it.window_low = w[63:0];
      it.window_high = w[127:64];
      it.opcode_length = ol;
      it.has_modrm = hm;
      it.immediate_length = il;
      it.index_shift = sh;
      it.drain = drain;
      pending_words.push_back(it);
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s got %0h want %0h", words_checked, field, got,
                                   want));
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         // hold until taken
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].drain && expected_decodes.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         driven_word = pending_words.pop_front();
         req_window_low <= driven_word.window_low;
         req_window_high <= driven_word.window_high;
         req_opcode_length <= driven_word.opcode_length;
         req_has_modrm <= driven_word.has_modrm;
         req_immediate_length <= driven_word.immediate_length;
         req_index_shift <= driven_word.index_shift;
         req_valid <= 1'b1;
         send_gap = pick_gap(send_calm);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap(stall_calm);
      end
   end

   always @(posedge clock) begin
      decode_result_type want;
      word_taken = req_valid && req_ready;
      if (!reset) begin
         if (word_taken) expected_decodes.push_back(decode_expect(driven_word));
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("decoded word with nothing outstanding");
            end else begin
               want = expected_decodes.pop_front();
               compare_field("prefix_flags", 32'(rsp_prefix_flags), 32'(want.flags));
               compare_field("segment_override", 32'(rsp_segment_override), 32'(want.seg));
               compare_field("modrm_value", 32'(rsp_modrm_value), 32'(want.modrm));
               compare_field("base_register", 32'(rsp_base_register), 32'(want.base));
               compare_field("index_register", 32'(rsp_index_register), 32'(want.index));
               compare_field("scale_factor", 32'(rsp_scale_factor), 32'(want.scale));
               compare_field("displacement", rsp_displacement, want.disp);
               compare_field("immediate_value", rsp_immediate_value, want.imm);
               compare_field("register_index", 32'(rsp_register_index), 32'(want.reg_index));
               compare_field("total_length", 32'(rsp_total_length), 32'(want.total));
               compare_field("decode_error", 32'(rsp_decode_error), 32'(want.err));
               words_checked++;
               if (want.err) error_words++;
               if (want.scale != 0) sib_words++;
            end
         end
      end
   end

   initial begin
      instr_word_type it;
      add_word(128'h0, 2'd1, 1'b0, 3'd0, 5'd0, 1'b0);
      add_word('1, 2'd3, 1'b1, 3'd4, 5'd31, 1'b0);
      add_word(128'hBEEF1234_5678050F_6766F3F2, 2'd1, 1'b1, 3'd2, 5'd3, 1'b0);
      add_word(128'h7F80_25448B3E_362E26F0, 2'd1, 1'b1, 3'd1, 5'd8, 1'b0);
      add_word(128'hDD_CCBBAAE5_048D6564, 2'd1, 1'b1, 3'd0, 5'd5, 1'b0);
      add_word(128'h90F0_F0F0_F0F0_F0F0_F0F0_F0F0_F0F0_F0F0, 2'd2, 1'b1, 3'd4, 5'd16, 1'b0);
      add_word({16{8'h26}}, 2'd1, 1'b0, 3'd0, 5'd1, 1'b0);
      add_word(128'h1122334480000000_4B848B, 2'd1, 1'b1, 3'd4, 5'd24, 1'b0);
      add_word(128'hAAC88966, 2'd1, 1'b1, 3'd1, 5'd11, 1'b1);
      add_word(128'h008B, 2'd0, 1'b1, 3'd3, 5'd2, 1'b0);
      add_word(128'h7F458B, 2'd1, 1'b1, 3'd5, 5'd29, 1'b0);
      add_word(128'h1234880C00380FF067, 2'd3, 1'b1, 3'd2, 5'd7, 1'b0);
      add_word(128'h3412_C0FF_EE00_6AAB, 2'd2, 1'b0, 3'd6, 5'd30, 1'b0);
      add_word(128'h5555_AAAA_0A0B_0C0D, 2'd1, 1'b1, 3'd7, 5'd13, 1'b0);
      add_word(128'h6565_6565, 2'd3, 1'b1, 3'd4, 5'd20, 1'b0);
      directed_words = pending_words.size();
      for (int i = 0; i < RandomWords; i++) begin
         it = random_word();
         it.drain = (i % 250 == 249);
         pending_words.push_back(it);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_decodes.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      $display("checked %0d decoded words: %0d directed, %0d random", words_checked,
               directed_words, RandomWords);
      $display("%0d carried a SIB byte, %0d were flagged as decode errors", sib_words,
               error_words);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d words outstanding", expected_decodes.size());
      $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/x86dec_pkg.sv
hw/rtl/x86dec_prefix_scan.sv
hw/rtl/x86_prefix_modrm_sib_decoder_top.sv
hw/rtl/x86dec_checker.sv
bench/x86_prefix_modrm_sib_decoder_top_tb.sv
